// ----- hdl/cpc_pkg.sv -----
// Shared constants for the capsule point classifier: formats, register
// indexes and verdict codes. No dependencies.
`default_nettype none

package cpc_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int TOL_WIDTH       = 16;
    localparam int CFG_ADDR_WIDTH  = 8;
    localparam int VERDICT_WIDTH   = 2;
    localparam int OUT_DATA_WIDTH  = 8;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_TOP_X  = 8'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_TOP_Y  = 8'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_TOP_Z  = 8'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_BASE_X = 8'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_BASE_Y = 8'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_BASE_Z = 8'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RADIUS = 8'd6;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_TOL    = 8'd7;

    localparam logic [VERDICT_WIDTH-1:0] V_INNER  = 2'd0;
    localparam logic [VERDICT_WIDTH-1:0] V_BORDER = 2'd1;
    localparam logic [VERDICT_WIDTH-1:0] V_OUTER  = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/capsule_point_classifier.sv -----
// Capsule point classifier: seven-stage pipeline, exact squared compares.
// Depends on cpc_pkg.
//
// Throughput: one point per cycle while the output is not stalled; each stage
// holds only when its successor is full and stalled, so bubbles collapse under
// output backpressure.
// Reset (synchronous, i_rst_n low) empties the pipe and loads the default
// capsule: base at origin, top at z = 1.0, radius 1.0, tolerance one LSB.
`default_nettype none

module capsule_point_classifier #(
    parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = cpc_pkg::FRAC_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // config write channel
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [cpc_pkg::CFG_ADDR_WIDTH-1:0]    i_cfg_addr,
    input  wire  [COORD_WIDTH-1:0]                i_cfg_data,
    // point stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // px, py, pz, zero pad
    // verdict stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [cpc_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata   // verdict, zero pad
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;          // coordinate difference
    localparam int PW   = 2 * DW;          // product of two differences
    localparam int UW   = 2 * CW + 2;      // dot products, squared bounds
    localparam int H    = UW / 2;          // multiplier limb
    localparam int BW   = 2 * UW;          // full wide products
    localparam int TW   = cpc_pkg::TOL_WIDTH;
    localparam int TDW  = TW + UW;         // tol * dd
    localparam int CMPW = UW + FRAC_BITS + TW + 2;
    localparam int VW   = cpc_pkg::VERDICT_WIDTH;
    localparam int NS   = 7;

    // ---------------- configuration ----------------
    logic signed [CW-1:0] r_top [3];
    logic signed [CW-1:0] r_base[3];
    logic [CW-2:0]        r_rad;
    logic [TW-1:0]        r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top[0]  <= '0;
            r_top[1]  <= '0;
            r_top[2]  <= CW'(1) << FRAC_BITS;
            r_base[0] <= '0;
            r_base[1] <= '0;
            r_base[2] <= '0;
            r_rad     <= (CW-1)'(1) << FRAC_BITS;
            r_tol     <= TW'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                cpc_pkg::REG_TOP_X:  r_top[0]  <= i_cfg_data;
                cpc_pkg::REG_TOP_Y:  r_top[1]  <= i_cfg_data;
                cpc_pkg::REG_TOP_Z:  r_top[2]  <= i_cfg_data;
                cpc_pkg::REG_BASE_X: r_base[0] <= i_cfg_data;
                cpc_pkg::REG_BASE_Y: r_base[1] <= i_cfg_data;
                cpc_pkg::REG_BASE_Z: r_base[2] <= i_cfg_data;
                cpc_pkg::REG_RADIUS: r_rad     <= i_cfg_data[CW-2:0];
                cpc_pkg::REG_TOL:    r_tol     <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage control ----------------
    logic [NS:1] r_v;
    logic [NS:1] w_en;

    always_comb begin
        w_en[NS] = !r_v[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = NS; k >= 2; k--) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
            if (w_en[1]) r_v[1] <= s_axis_tvalid;
        end
    end

    function automatic logic [VW-1:0] f_judge(input logic [BW-1:0] q, input logic [BW-1:0] lo,
                                              input logic [BW-1:0] hi, input logic look);
        logic [VW-1:0] v;
        begin
            v = cpc_pkg::V_OUTER;
            if (look && q < lo) v = cpc_pkg::V_INNER;
            else if ((!look || lo < q) && q < hi) v = cpc_pkg::V_BORDER;
            return v;
        end
    endfunction

    // ---------------- stage 1: differences, bounds ----------------
    logic signed [CW-1:0] w_p[3];
    assign w_p[0] = $signed(s_axis_tdata[CW-1:0]);
    assign w_p[1] = $signed(s_axis_tdata[2*CW-1:CW]);
    assign w_p[2] = $signed(s_axis_tdata[3*CW-1:2*CW]);

    logic signed [DW-1:0] r1_h[3], r1_g[3], r1_d[3];
    logic [H-1:0]         r1_rpt, r1_rmt;
    logic                 r1_look;
    logic [H-1:0]         w_radx, w_tolx;

    assign w_radx = H'(r_rad);
    assign w_tolx = H'(r_tol);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_h[i] <= DW'(w_p[i]) - DW'(r_base[i]);
                r1_g[i] <= DW'(w_p[i]) - DW'(r_top[i]);
                r1_d[i] <= DW'(r_top[i]) - DW'(r_base[i]);
            end
            r1_rpt  <= w_radx + w_tolx;
            r1_rmt  <= (w_radx >= w_tolx) ? w_radx - w_tolx : w_tolx - w_radx;
            r1_look <= w_radx >= w_tolx;
        end
    end

    // ---------------- stage 2: elementwise products ----------------
    logic signed [PW-1:0] r2_hd[3], r2_dd[3], r2_hh[3], r2_gg[3];
    logic [UW-1:0]        r2_lo2, r2_hi2;
    logic                 r2_look;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_hd[i] <= r1_h[i] * r1_d[i];
                r2_dd[i] <= r1_d[i] * r1_d[i];
                r2_hh[i] <= r1_h[i] * r1_h[i];
                r2_gg[i] <= r1_g[i] * r1_g[i];
            end
            r2_lo2  <= r1_rmt * r1_rmt;
            r2_hi2  <= r1_rpt * r1_rpt;
            r2_look <= r1_look;
        end
    end

    // ---------------- stage 3: dot products ----------------
    logic signed [UW:0] w_hd, w_dd, w_hh, w_gg;
    assign w_hd = (UW+1)'(r2_hd[0]) + (UW+1)'(r2_hd[1]) + (UW+1)'(r2_hd[2]);
    assign w_dd = (UW+1)'(r2_dd[0]) + (UW+1)'(r2_dd[1]) + (UW+1)'(r2_dd[2]);
    assign w_hh = (UW+1)'(r2_hh[0]) + (UW+1)'(r2_hh[1]) + (UW+1)'(r2_hh[2]);
    assign w_gg = (UW+1)'(r2_gg[0]) + (UW+1)'(r2_gg[1]) + (UW+1)'(r2_gg[2]);

    logic signed [UW:0] r3_hd;
    logic [UW-1:0]      r3_ahd, r3_dd, r3_hh, r3_gg, r3_lo2, r3_hi2;
    logic               r3_look;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_hd   <= w_hd;
            r3_ahd  <= w_hd[UW] ? UW'(-w_hd) : w_hd[UW-1:0];
            r3_dd   <= w_dd[UW-1:0];
            r3_hh   <= w_hh[UW-1:0];
            r3_gg   <= w_gg[UW-1:0];
            r3_lo2  <= r2_lo2;
            r3_hi2  <= r2_hi2;
            r3_look <= r2_look;
        end
    end

    // ---------------- stage 4: limb products, sphere verdict ----------------
    logic [VW-1:0] w_va, w_vb;
    assign w_va = f_judge(BW'(r3_hh), BW'(r3_lo2), BW'(r3_hi2), r3_look);
    assign w_vb = f_judge(BW'(r3_gg), BW'(r3_lo2), BW'(r3_hi2), r3_look);

    logic [UW-1:0]      r4_m00, r4_m01, r4_m10, r4_m11;   // hh * dd
    logic [UW-1:0]      r4_a00, r4_a01, r4_a11;           // hd * hd
    logic [UW-1:0]      r4_l00, r4_l01, r4_l10, r4_l11;   // lo2 * dd
    logic [UW-1:0]      r4_u00, r4_u01, r4_u10, r4_u11;   // hi2 * dd
    logic [TW+H-1:0]    r4_t0, r4_t1;                     // tol * dd
    logic signed [UW:0] r4_hd;
    logic [UW-1:0]      r4_dd;
    logic               r4_look;
    logic [VW-1:0]      r4_vs;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_m00  <= r3_hh[H-1:0]    * r3_dd[H-1:0];
            r4_m01  <= r3_hh[H-1:0]    * r3_dd[UW-1:H];
            r4_m10  <= r3_hh[UW-1:H]   * r3_dd[H-1:0];
            r4_m11  <= r3_hh[UW-1:H]   * r3_dd[UW-1:H];
            r4_a00  <= r3_ahd[H-1:0]   * r3_ahd[H-1:0];
            r4_a01  <= r3_ahd[H-1:0]   * r3_ahd[UW-1:H];
            r4_a11  <= r3_ahd[UW-1:H]  * r3_ahd[UW-1:H];
            r4_l00  <= r3_lo2[H-1:0]   * r3_dd[H-1:0];
            r4_l01  <= r3_lo2[H-1:0]   * r3_dd[UW-1:H];
            r4_l10  <= r3_lo2[UW-1:H]  * r3_dd[H-1:0];
            r4_l11  <= r3_lo2[UW-1:H]  * r3_dd[UW-1:H];
            r4_u00  <= r3_hi2[H-1:0]   * r3_dd[H-1:0];
            r4_u01  <= r3_hi2[H-1:0]   * r3_dd[UW-1:H];
            r4_u10  <= r3_hi2[UW-1:H]  * r3_dd[H-1:0];
            r4_u11  <= r3_hi2[UW-1:H]  * r3_dd[UW-1:H];
            r4_t0   <= (TW+H)'(r_tol)  * (TW+H)'(r3_dd[H-1:0]);
            r4_t1   <= (TW+H)'(r_tol)  * (TW+H)'(r3_dd[UW-1:H]);
            r4_hd   <= r3_hd;
            r4_dd   <= r3_dd;
            r4_look <= r3_look;
            r4_vs   <= (w_va < w_vb) ? w_va : w_vb;
        end
    end

    // ---------------- stage 5: assemble wide products ----------------
    logic [BW-1:0]      r5_hhdd, r5_hdhd, r5_lodd, r5_hidd;
    logic [TDW-1:0]     r5_tdd;
    logic signed [UW:0] r5_hd;
    logic [UW-1:0]      r5_dd;
    logic               r5_look;
    logic [VW-1:0]      r5_vs;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_hhdd <= {r4_m11, r4_m00} + ((BW'(r4_m01) + BW'(r4_m10)) << H);
            r5_hdhd <= {r4_a11, r4_a00} + (BW'(r4_a01) << (H + 1));
            r5_lodd <= {r4_l11, r4_l00} + ((BW'(r4_l01) + BW'(r4_l10)) << H);
            r5_hidd <= {r4_u11, r4_u00} + ((BW'(r4_u01) + BW'(r4_u10)) << H);
            r5_tdd  <= TDW'(r4_t0) + (TDW'(r4_t1) << H);
            r5_hd   <= r4_hd;
            r5_dd   <= r4_dd;
            r5_look <= r4_look;
            r5_vs   <= r4_vs;
        end
    end

    // ---------------- stage 6: axis distance, end-cap decision ----------------
    // sphere path when d is zero or t lies outside [-tol, 1 + tol]
    logic signed [CMPW-1:0] w_lhs, w_neg, w_pos, w_tdd, w_dds;
    assign w_lhs = CMPW'(r5_hd) <<< FRAC_BITS;
    assign w_tdd = $signed(CMPW'(r5_tdd));
    assign w_dds = $signed(CMPW'(r5_dd)) <<< FRAC_BITS;
    assign w_neg = -w_tdd;
    assign w_pos = w_dds + w_tdd;

    logic [BW-1:0] r6_q, r6_lodd, r6_hidd;
    logic          r6_sphere, r6_look;
    logic [VW-1:0] r6_vs;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_q      <= r5_hhdd - r5_hdhd;
            r6_lodd   <= r5_lodd;
            r6_hidd   <= r5_hidd;
            r6_sphere <= (r5_dd == '0) || (w_lhs < w_neg) || (w_pos < w_lhs);
            r6_look   <= r5_look;
            r6_vs     <= r5_vs;
        end
    end

    // ---------------- stage 7: output register ----------------
    logic [VW-1:0] r7_v;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_v <= r6_sphere ? r6_vs : f_judge(r6_q, r6_lodd, r6_hidd, r6_look);
        end
    end

    assign m_axis_tvalid = r_v[NS];
    assign m_axis_tdata  = cpc_pkg::OUT_DATA_WIDTH'(r7_v);

endmodule

`default_nettype wire

// ----- hdl/cpc_checker.sv -----
// Port-level checks for the capsule point classifier, bound to the top level.
// Depends on cpc_pkg and capsule_point_classifier.
`default_nettype none

module cpc_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [cpc_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata
);

    localparam int DEPTH = 7;

    // requests in flight: accepted points whose verdict is not yet taken
    logic [3:0] r_cnt;
    logic       w_in, w_out;
    assign w_in  = s_axis_tvalid && s_axis_tready;
    assign w_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= r_cnt + 4'(w_in) - 4'(w_out);
    end

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 4'd0) |-> !m_axis_tvalid)
        else $error("verdict with no request in flight");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == cpc_pkg::V_INNER ||
                           m_axis_tdata[1:0] == cpc_pkg::V_BORDER ||
                           m_axis_tdata[1:0] == cpc_pkg::V_OUTER))
        else $error("undefined verdict code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled verdict dropped or changed");

endmodule

bind capsule_point_classifier cpc_checker u_cpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
